/* src/dst_pkg.sv */
`timescale 1ns / 1ps

package dst_pkg;

   localparam int CAPACITY   = 64;
   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int COUNT_W    = 7;
   localparam int ELEM_W     = 32;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_QUERY  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_DUP    = 2'd1,
      STATUS_ABSENT = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_REDUCE = 2'd1,
      ST_UPDATE = 2'd2
   } state_type;

   typedef struct packed {
      func_type                   func;
      logic signed [ELEM_W-1:0]   element;
   } req_type;

   typedef struct packed {
      logic                 found;
      status_type           status;
      logic [COUNT_W-1:0]   count;
   } rsp_type;

   // Per-cell update command.
   typedef struct packed {
      logic load_new;
      logic shift;
   } cell_ctl_type;

   // Row-wide command from the sequencer.
   typedef struct packed {
      logic match_en;
      logic group_en;
      logic insert_new;
      logic compact;
   } chain_cmd_type;

endpackage

/* src/dst_cell.sv */
`timescale 1ns / 1ps

module dst_cell import dst_pkg::*; (
   input  logic                       clock,
   input  logic signed [ELEM_W-1:0]   element,
   input  logic                       live,
   input  logic                       match_en,
   input  logic                       seen_in,
   input  cell_ctl_type               ctl,
   input  logic signed [ELEM_W-1:0]   next_entry,
   output logic signed [ELEM_W-1:0]   entry,
   output logic                       match,
   output logic                       seen_out
);

   logic signed [ELEM_W-1:0] entry_ff, entry_in;
   logic                     match_ff, match_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load_new) begin
         entry_in = element;
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end
      match_in = match_en ? (live && (entry_ff == element)) : match_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry    = entry_ff;
   assign match    = match_ff;
   // Hand the "match at or before me" flag to the next cell in the group.
   assign seen_out = seen_in | match_ff;

endmodule

/* src/dst_chain.sv */
`timescale 1ns / 1ps

module dst_chain import dst_pkg::*; (
   input  logic                       clock,
   input  logic signed [ELEM_W-1:0]   element,
   input  logic [CNT_W-1:0]           count,
   input  chain_cmd_type              cmd,
   output logic                       found
);

   logic [CAPACITY-1:0]      live, tail, match, seen_in, seen_out, next_live;
   logic signed [ELEM_W-1:0] entry      [CAPACITY];
   logic signed [ELEM_W-1:0] next_entry [CAPACITY];
   cell_ctl_type             ctl        [CAPACITY];
   logic [NUM_GROUPS-1:0]    group_hit_ff, group_hit_in, earlier;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         assign live[i] = CNT_W'(i) < count;
         assign tail[i] = CNT_W'(i) == count;

         if ((i % GROUP_SIZE) == 0) begin : g_head
            assign seen_in[i] = 1'b0;
         end else begin : g_body
            assign seen_in[i] = seen_out[i-1];
         end

         if (i == CAPACITY - 1) begin : g_last
            assign next_entry[i] = entry[i];
            assign next_live[i]  = 1'b0;
         end else begin : g_mid
            assign next_entry[i] = entry[i+1];
            assign next_live[i]  = live[i+1];
         end

         // Shift down each cell at or past the removed entry whose next cell is live.
         assign ctl[i].load_new = cmd.insert_new & tail[i];
         assign ctl[i].shift    = cmd.compact & next_live[i]
                                  & (earlier[i / GROUP_SIZE] | seen_out[i]);

         dst_cell u_cell (
            .clock      (clock),
            .element    (element),
            .live       (live[i]),
            .match_en   (cmd.match_en),
            .seen_in    (seen_in[i]),
            .ctl        (ctl[i]),
            .next_entry (next_entry[i]),
            .entry      (entry[i]),
            .match      (match[i]),
            .seen_out   (seen_out[i])
         );
      end
   endgenerate

   always_comb begin
      group_hit_in = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         group_hit_in[k / GROUP_SIZE] = group_hit_in[k / GROUP_SIZE] | match[k];
      end
   end

   always_comb begin
      earlier = '0;
      for (int g = 1; g < NUM_GROUPS; g++) begin
         earlier[g] = earlier[g-1] | group_hit_ff[g-1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.group_en) begin
         group_hit_ff <= group_hit_in;
      end
   end

   assign found = |group_hit_ff;

endmodule

/* src/dedup_set_table.sv */
`timescale 1ns / 1ps
// Compare, group-reduce and update run in turn over the one row of cells, which
// holds one request at a time: a new request is taken only after the update step
// has registered the last one's response, and that step waits while one is held.
// The response register frees the request side while a response waits.
// Reset (synchronous, active high) empties the set and drops any pending response.

module dedup_set_table import dst_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp
);

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   chain_cmd_type      cmd;
   logic               found_any;
   logic               rsp_free;
   logic               accept;

   // The row of cells: each stores one entry, compares it with the request
   // value and hands its entry to the cell below during compaction.
   dst_chain u_chain (
      .clock   (clock),
      .element (accept ? req.element : req_ff.element),
      .count   (count_ff),
      .cmd     (cmd),
      .found   (found_any)
   );

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   always_comb begin
      logic       hit;
      logic       full;
      state_in       = state_ff;
      req_in         = req_ff;
      count_in       = count_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      req_ready      = 1'b0;
      cmd            = '0;
      hit            = (req_ff.func != FUNC_CLEAR) && found_any;
      full           = count_ff == CNT_W'(CAPACITY);

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // Latch the request and register each cell's compare.
               req_in       = req;
               cmd.match_en = 1'b1;
               state_in     = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.group_en = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (rsp_free) begin
               rsp_in.found  = hit;
               rsp_in.status = STATUS_DONE;
               case (req_ff.func)
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  FUNC_INSERT: begin
                     if (hit) begin
                        rsp_in.status = STATUS_DUP;
                     end else if (full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        cmd.insert_new = 1'b1;
                        count_in       = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_REMOVE: begin
                     if (!hit) begin
                        rsp_in.status = STATUS_ABSENT;
                     end else begin
                        cmd.compact = 1'b1;
                        count_in    = count_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     // query: set unchanged
                  end
               endcase
               rsp_in.count = COUNT_W'(count_in);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: hold until the next request or response overwrites it.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* src/dst_checker.sv */
`timescale 1ns / 1ps

module dst_checker import dst_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      req_ready,
   input  req_type   req,
   input  logic      rsp_valid,
   input  logic      rsp_ready,
   input  rsp_type   rsp
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("response dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.count <= COUNT_W'(CAPACITY))
      else $error("count beyond capacity");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == STATUS_FULL |-> !rsp.found && rsp.count == COUNT_W'(CAPACITY))
      else $error("full status without a full set");

   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.status != STATUS_DUP || rsp.found)
                 && (rsp.status != STATUS_ABSENT || !rsp.found))
      else $error("status disagrees with found");

endmodule

bind dedup_set_table dst_checker u_dst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);

/* tb/dedup_set_table_chk.sv */
`timescale 1ns / 1ps

module dedup_set_table_chk import dst_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      req_ready,
   input  req_type   req,
   input  logic      rsp_valid,
   input  logic      rsp_ready,
   input  rsp_type   rsp,
   output int        fail_count,
   output int        answers_pending,
   output int        answers_checked,
   output int        full_drops,
   output int        dup_inserts,
   output int        absent_removes,
   output int        peak_count
);

   // Shadow copy of the set, kept in insertion order.
   logic signed [ELEM_W-1:0] members [CAPACITY];
   int                       member_count;

   rsp_type expected_answers [$];

   int mismatches;
   int checked;
   int n_full;
   int n_dup;
   int n_absent;
   int n_peak;

   function automatic rsp_type apply_to_set(input req_type item);
      rsp_type answer;
      int      hit;
      answer.found  = 1'b0;
      answer.status = STATUS_DONE;
      hit           = -1;
      if (item.func == FUNC_CLEAR) begin
         member_count = 0;
      end else begin
         for (int i = 0; i < member_count; i++) begin
            if (hit < 0 && members[i] == item.element) hit = i;
         end
         answer.found = (hit >= 0);
         case (item.func)
            FUNC_INSERT: begin
               if (hit >= 0) begin
                  answer.status = STATUS_DUP;
               end else if (member_count >= CAPACITY) begin
                  answer.status = STATUS_FULL;
               end else begin
                  members[member_count] = item.element;
                  member_count++;
               end
            end
            FUNC_REMOVE: begin
               if (hit < 0) begin
                  answer.status = STATUS_ABSENT;
               end else begin
                  // close the gap left by the removed entry
                  for (int j = hit; j + 1 < member_count; j++) members[j] = members[j + 1];
                  member_count--;
               end
            end
            default: ;
         endcase
      end
      answer.count = COUNT_W'(member_count);
      return answer;
   endfunction

   task automatic note_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (mismatches < 10) begin
         $display("%0t: response %0d, %s mismatch: expected %0d, got %0d",
                  $realtime, checked, field, want, got);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_type answer;
      rsp_type want;
      if (reset) begin
         member_count = 0;
         expected_answers.delete();
      end else begin
         if (req_valid && req_ready) begin
            answer = apply_to_set(req);
            expected_answers.push_back(answer);
            if (answer.status == STATUS_FULL) n_full++;
            if (answer.status == STATUS_DUP) n_dup++;
            if (answer.status == STATUS_ABSENT) n_absent++;
            if (member_count > n_peak) n_peak = member_count;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               if (mismatches < 10) begin
                  $display("%0t: response with no request outstanding (found %0d status %0d count %0d)",
                           $realtime, rsp.found, rsp.status, rsp.count);
               end
               mismatches++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp.found !== want.found)
                  note_mismatch("found", 32'(want.found), 32'(rsp.found));
               if (rsp.status !== want.status)
                  note_mismatch("status", 32'(want.status), 32'(rsp.status));
               if (rsp.count !== want.count)
                  note_mismatch("count", 32'(want.count), 32'(rsp.count));
            end
            checked++;
         end
      end
      fail_count      <= mismatches;
      answers_pending <= expected_answers.size();
      answers_checked <= checked;
      full_drops      <= n_full;
      dup_inserts     <= n_dup;
      absent_removes  <= n_absent;
      peak_count      <= n_peak;
   end

endmodule

/* tb/dedup_set_table_tb.sv */
`timescale 1ns / 1ps

module dedup_set_table_tb import dst_pkg::*; ();

   localparam int REQUEST_TARGET = 850;
   localparam int STALL_LIMIT    = 2000;  // cycles with no handshake before giving up
   localparam int HOLD_OFF       = 300;   // long response-side stall, in cycles
   localparam int HOLD_AFTER     = 250;   // responses taken before the long stall

   localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
   localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp;

   int chk_fail_count;
   int chk_pending;
   int chk_checked;
   int chk_full_drops;
   int chk_dup_inserts;
   int chk_absent_removes;
   int chk_peak_count;

   int requests_sent;
   bit no_idle;   // when set, both sides run back to back

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dedup_set_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   dedup_set_table_chk u_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req             (req),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp             (rsp),
      .fail_count      (chk_fail_count),
      .answers_pending (chk_pending),
      .answers_checked (chk_checked),
      .full_drops      (chk_full_drops),
      .dup_inserts     (chk_dup_inserts),
      .absent_removes  (chk_absent_removes),
      .peak_count      (chk_peak_count)
   );

   // Offer one request after a random gap and hold it until the block takes it.
   // Drive at the falling edge; look for the handshake at the rising edge.
   task automatic send_request(input func_type op, input logic signed [ELEM_W-1:0] value);
      req_type item;
      int      gap;
      item.func    = op;
      item.element = value;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         // drop valid for the gap, then raise it with the new payload
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req       <= item;
      do @(posedge clock); while (!(req_valid && req_ready));
      requests_sent++;
   endtask

   // Fill the set to capacity, poke at it while full, then churn around the bound.
   task automatic run_fill_phase();
      logic signed [ELEM_W-1:0] stored [$];
      logic signed [ELEM_W-1:0] value;
      int                       k;
      send_request(FUNC_CLEAR, $urandom);
      for (int n = 0; n < CAPACITY; n++) begin
         value = $urandom;
         stored.push_back(value);
         send_request(FUNC_INSERT, value);
         if ($urandom_range(0, 7) == 0) begin
            send_request(FUNC_QUERY, stored[$urandom_range(0, stored.size() - 1)]);
         end
      end
      // full now: new values get dropped, members still report duplicate
      repeat (3) send_request(FUNC_INSERT, $urandom);
      send_request(FUNC_INSERT, stored[$urandom_range(0, stored.size() - 1)]);
      send_request(FUNC_QUERY, stored[stored.size() - 1]);
      send_request(FUNC_QUERY, $urandom);
      repeat (24) begin
         k = $urandom_range(0, stored.size() - 1);
         case ($urandom_range(0, 2))
            0: begin
               // remove from anywhere in the order to force compaction
               send_request(FUNC_REMOVE, stored[k]);
               stored.delete(k);
            end
            1: begin
               value = $urandom;
               stored.push_back(value);
               send_request(FUNC_INSERT, value);
            end
            default: send_request(FUNC_QUERY, stored[k]);
         endcase
         if (stored.size() == 0) stored.push_back($urandom);
      end
   endtask

   // Mixed operations over a small pool of values so that hits are common.
   task automatic run_churn_phase();
      logic signed [ELEM_W-1:0] pool [10];
      int                       len;
      int                       pick;
      for (int i = 0; i < 10; i++) begin
         case ($urandom_range(0, 7))
            0:       pool[i] = ELEM_MIN;
            1:       pool[i] = ELEM_MAX;
            2:       pool[i] = '0;
            3:       pool[i] = '1;
            default: pool[i] = $urandom;
         endcase
      end
      len = $urandom_range(20, 40);
      repeat (len) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            send_request(FUNC_CLEAR, $urandom);
         end else if (pick <= 8) begin
            send_request(FUNC_INSERT, pool[$urandom_range(0, 9)]);
         end else if (pick <= 14) begin
            send_request(FUNC_REMOVE, pool[$urandom_range(0, 9)]);
         end else begin
            send_request(FUNC_QUERY, pool[$urandom_range(0, 9)]);
         end
      end
   endtask

   // Fully random operation and value.
   task automatic run_noise_phase();
      int len;
      len = $urandom_range(10, 25);
      repeat (len) send_request(func_type'($urandom_range(0, 3)), $urandom);
   endtask

   // Response side: stall a random number of cycles per response, and once
   // hold off for a long stretch so the block backs up and stalls its input.
   initial begin
      int  stall;
      int  taken;
      bit  held;
      taken = 0;
      held  = 1'b0;
      rsp_ready <= 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (!held && taken == HOLD_AFTER) begin
            held = 1'b1;
            stall = HOLD_OFF;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 12);
         end
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Timeout: no handshake for %0d cycles, %0d responses outstanding",
               STALL_LIMIT, chk_pending);
      $display("Test completed with failures");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      requests_sent = 0;
      no_idle       = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req       <= '0;

      // hold reset, then release it at a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty set, field extremes, every operation and every status but full
      send_request(FUNC_CLEAR, 32'h5A5A_A5A5);
      send_request(FUNC_QUERY, '0);
      send_request(FUNC_REMOVE, '0);
      send_request(FUNC_INSERT, ELEM_MIN);
      send_request(FUNC_INSERT, ELEM_MAX);
      send_request(FUNC_INSERT, '0);
      send_request(FUNC_INSERT, '1);
      send_request(FUNC_INSERT, 32'sd1);
      send_request(FUNC_INSERT, ELEM_MIN);       // duplicate
      send_request(FUNC_QUERY, ELEM_MAX);        // present
      send_request(FUNC_QUERY, 32'sd2);          // absent
      send_request(FUNC_REMOVE, '0);             // middle entry, later ones shift down
      send_request(FUNC_REMOVE, ELEM_MIN);       // first entry
      send_request(FUNC_REMOVE, 32'sd1);         // last entry
      send_request(FUNC_REMOVE, 32'sd1);         // now absent
      send_request(FUNC_QUERY, '1);
      send_request(FUNC_INSERT, 32'h5555_5555);
      send_request(FUNC_INSERT, 32'hAAAA_AAAA);
      send_request(FUNC_CLEAR, '1);
      send_request(FUNC_QUERY, ELEM_MAX);        // gone after clear
      send_request(FUNC_INSERT, ELEM_MAX);

      // random: start with a fill so the full-set drop is always reached
      run_fill_phase();
      while (requests_sent < REQUEST_TARGET) begin
         no_idle = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 5))
            0, 1, 2: run_churn_phase();
            3:       run_fill_phase();
            default: run_noise_phase();
         endcase
      end
      no_idle = 1'b0;

      // drop valid, drain outstanding responses, then allow a few more cycles
      @(negedge clock);
      req_valid <= 1'b0;
      while (chk_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);

      $display("Ran %0d requests, checked %0d responses; peak occupancy %0d of %0d.",
               requests_sent, chk_checked, chk_peak_count, CAPACITY);
      $display("Full-set drops %0d, duplicate inserts %0d, removes of absent values %0d.",
               chk_full_drops, chk_dup_inserts, chk_absent_removes);
      if (chk_fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", chk_fail_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
